@@ hdl/lcs_pkg.sv @@
`timescale 1ns / 1ps
// lcs_pkg: shared types and constants of the LCS length engine.
// No dependencies; used by lcs_seq_mem, lcs_row_unit and lcs_length_engine.
package lcs_pkg;

  // element width and output field widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned LEN_OUT_W  = 9;
  localparam int unsigned M_TDATA_W  = 16;

  // tuser kind on the slave side
  localparam logic CMD_FIRST  = 1'b0;
  localparam logic CMD_SECOND = 1'b1;

  // per-cycle control from the sweep sequencer to the row unit
  typedef struct packed {
    logic rd_en;       // a row entry is read this cycle
    logic start;       // first entry of a sweep
    logic first_pass;  // first B element of a run: stored row reads as zero
  } sweep_ctl_t;

endpackage

@@ hdl/lcs_seq_mem.sv @@
`timescale 1ns / 1ps
// lcs_seq_mem: storage for the elements of the first sequence.
// One write port, one read port with registered data. Uses lcs_pkg.
module lcs_seq_mem #(
  parameter int unsigned AW = 8
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [lcs_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [lcs_pkg::DATA_W-1:0] rd_data
);

  logic [lcs_pkg::DATA_W-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/lcs_row_unit.sv @@
`timescale 1ns / 1ps
// lcs_row_unit: dynamic-programming row memory and its update datapath.
// Reads one entry a cycle, updates it the next cycle and writes it back. Uses lcs_pkg.
module lcs_row_unit #(
  parameter int unsigned AW = 8,
  parameter int unsigned CW = 9
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lcs_pkg::sweep_ctl_t        ctl,
  input  logic [AW-1:0]              rd_addr,
  input  logic [lcs_pkg::DATA_W-1:0] a_elem,   // registered store data, aligned to row data
  input  logic [lcs_pkg::DATA_W-1:0] b_elem,
  output logic [CW-1:0]              tail_val  // newest value written by the sweep
);

  logic [CW-1:0] row [2**AW];
  logic [CW-1:0] row_q;
  logic [AW-1:0] wr_addr;
  logic          upd_vld;
  logic          upd_start;
  logic          upd_first;
  logic [CW-1:0] diag;
  logic [CW-1:0] above;

  logic [CW-1:0] left_use;
  logic [CW-1:0] diag_use;
  logic [CW-1:0] above_use;
  logic [CW-1:0] new_val;

  // read stage
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      row_q <= row[rd_addr];
    end
    wr_addr   <= rd_addr;
    upd_start <= ctl.start;
    upd_first <= ctl.first_pass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_vld <= 1'b0;
    end else begin
      upd_vld <= ctl.rd_en;
    end
  end

  // cell update: diagonal plus one on a match, else larger of left and above
  always_comb begin
    left_use  = upd_first ? '0 : row_q;
    diag_use  = upd_start ? '0 : diag;
    above_use = upd_start ? '0 : above;
    if (a_elem == b_elem) begin
      new_val = diag_use + CW'(1);
    end else if (left_use > above_use) begin
      new_val = left_use;
    end else begin
      new_val = above_use;
    end
  end

  // write back and carry neighbors along the row
  always_ff @(posedge clk) begin
    if (upd_vld) begin
      row[wr_addr] <= new_val;
      diag         <= left_use;
      above        <= new_val;
    end
  end

  assign tail_val = above;

endmodule

@@ hdl/lcs_length_engine.sv @@
`timescale 1ns / 1ps
// lcs_length_engine: top level, beat handling and sweep sequencer.
// Instantiates lcs_seq_mem and lcs_row_unit; uses lcs_pkg.
//
// Usage: slave beats carry sequence elements in s_tdata; s_tuser selects the
// sequence (0 = first sequence A, 1 = second sequence B) and s_tlast marks the
// last element of that sequence. Load A first, then stream B. After the last
// B beat one master beat returns the LCS length in m_tdata[8:0] and the
// truncation flag in m_tuser. Elements beyond MAX_LEN in either sequence are
// dropped and flag overflow. B may be streamed again against the same A.
// Throughput: A beats are taken without a stall. A B beat sweeps the stored
// row, one entry a cycle through the separate read and write ports of the row
// memory; s_tready stays low until the engine returns to ST_IDLE.
// The sweep runs through ST_SWEEP and ST_DRAIN to ST_FINISH (straight to
// ST_FINISH when A is empty or B is saturated); m_tvalid is set from ST_FINISH.
// Reset clears all control state; the row memory needs no clearing pass, the
// first B beat of each run treats stored row values as zero.
// If the receiver stalls, the result waits in the output register; further
// A/B beats that produce no result still proceed, and a second result waits
// until the first one has been taken.
module lcs_length_engine #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lcs_pkg::DATA_W-1:0]    s_tdata,  // [31:0] value
  input  logic                          s_tuser,  // [0] cmd
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lcs_pkg::M_TDATA_W-1:0] m_tdata,  // [8:0] lcs_length, rest zero
  output logic                          m_tuser   // [0] overflow
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                     state;
  logic [CW-1:0]              first_len;
  logic [CW-1:0]              second_count;
  logic                       overflow_seen;
  logic                       a_open;
  logic                       a_trunc;
  logic [CW-1:0]              idx;
  logic [lcs_pkg::DATA_W-1:0] b_val;
  logic                       b_last;
  logic                       first_pass;
  logic                       swept;
  logic [CW-1:0]              last_val;
  logic [CW-1:0]              out_len;

  logic                       beat_in;
  logic [CW-1:0]              a_base;
  logic                       a_wr;
  logic                       out_free;
  logic [CW-1:0]              res_len;
  logic [CW+lcs_pkg::LEN_OUT_W-1:0] res_ext;
  logic [lcs_pkg::DATA_W-1:0] a_q;
  logic [CW-1:0]              tail_val;
  lcs_pkg::sweep_ctl_t        ctl;

  assign s_tready = (state == ST_IDLE);
  assign beat_in  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // A write address: a new A restarts at zero
  assign a_base = a_open ? first_len : '0;
  assign a_wr   = beat_in && (s_tuser == lcs_pkg::CMD_FIRST) && (a_base < CW'(MAX_LEN));

  // sweep control
  always_comb begin
    ctl.rd_en      = (state == ST_SWEEP);
    ctl.start      = (state == ST_SWEEP) && (idx == '0);
    ctl.first_pass = first_pass;
  end

  lcs_seq_mem #(
    .AW(AW)
  ) u_seq_mem (
    .clk    (clk),
    .wr_en  (a_wr),
    .wr_addr(a_base[AW-1:0]),
    .wr_data(s_tdata),
    .rd_en  (ctl.rd_en),
    .rd_addr(idx[AW-1:0]),
    .rd_data(a_q)
  );

  lcs_row_unit #(
    .AW(AW),
    .CW(CW)
  ) u_row_unit (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_addr (idx[AW-1:0]),
    .a_elem  (a_q),
    .b_elem  (b_val),
    .tail_val(tail_val)
  );

  // result value: zero when A is empty
  assign res_len = (first_len == '0) ? '0 : (swept ? tail_val : last_val);
  assign res_ext = {{lcs_pkg::LEN_OUT_W{1'b0}}, out_len};
  assign m_tdata = {{(lcs_pkg::M_TDATA_W - lcs_pkg::LEN_OUT_W){1'b0}},
                    res_ext[lcs_pkg::LEN_OUT_W-1:0]};

  // B beat payload
  always_ff @(posedge clk) begin
    if (beat_in) begin
      b_val  <= s_tdata;
      b_last <= s_tlast;
    end
  end

  // sequencer, run state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_len     <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
      a_open        <= 1'b0;
      a_trunc       <= 1'b0;
      idx           <= '0;
      first_pass    <= 1'b0;
      swept         <= 1'b0;
      last_val      <= '0;
      m_tvalid      <= 1'b0;
      m_tuser       <= 1'b0;
      out_len       <= '0;
    end else begin
      // a taken result frees the output register unless a new one loads now
      if (m_tvalid && m_tready && !((state == ST_FINISH) && b_last)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (beat_in && (s_tuser == lcs_pkg::CMD_FIRST)) begin
            // element of A
            a_open <= !s_tlast;
            if (!a_open) begin
              second_count  <= '0;
              overflow_seen <= 1'b0;
              a_trunc       <= 1'b0;
            end
            if (a_base < CW'(MAX_LEN)) begin
              first_len <= a_base + CW'(1);
            end else begin
              first_len     <= a_base;
              overflow_seen <= 1'b1;
              a_trunc       <= 1'b1;
            end
          end else if (beat_in) begin
            // element of B
            a_open     <= 1'b0;
            first_pass <= (second_count == '0);
            idx        <= '0;
            if (second_count < CW'(MAX_LEN)) begin
              second_count <= second_count + CW'(1);
              if (second_count == '0) begin
                overflow_seen <= a_trunc;
              end
              swept <= (first_len != '0);
              state <= (first_len != '0) ? ST_SWEEP : ST_FINISH;
            end else begin
              overflow_seen <= 1'b1;
              swept         <= 1'b0;
              state         <= ST_FINISH;
            end
          end
        end
        ST_SWEEP: begin
          idx <= idx + CW'(1);
          if (idx + CW'(1) == first_len) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          last_val <= res_len;
          if (!b_last) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            m_tvalid      <= 1'b1;
            out_len       <= res_len;
            m_tuser       <= overflow_seen;
            second_count  <= '0;
            overflow_seen <= a_trunc;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for lcs_length_engine with an in-bench LCS row tracker.
// Depends on lcs_pkg and lcs_length_engine; reads no files.
module tb;

  localparam int unsigned LCS_MAX      = 256;
  localparam int          HOLD_CYCLES  = 3000;
  localparam int          CYCLE_LIMIT  = 2000000;
  localparam int          SETTLE_CYCLES = 400;
  localparam int          RANDOM_ITEMS = 200;

  typedef enum bit [1:0] {STIM_BEAT, STIM_DRAIN, STIM_HOLD} stim_kind_t;
  typedef enum bit [1:0] {PH_RX_SLOW, PH_TX_SLOW, PH_FREE} idle_phase_t;

  typedef struct {
    stim_kind_t                 kind;
    idle_phase_t                phase;
    logic                       cmd;
    logic [lcs_pkg::DATA_W-1:0] value;
    logic                       fin;
  } stim_item_t;

  typedef struct {
    logic [lcs_pkg::LEN_OUT_W-1:0] len;
    logic                          ovf;
  } lcs_result_t;

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [lcs_pkg::DATA_W-1:0]    s_tdata  = '0;   // [31:0] value
  logic                          s_tuser  = 1'b0; // [0] cmd
  logic                          s_tlast  = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [lcs_pkg::M_TDATA_W-1:0] m_tdata;         // [8:0] lcs_length, rest zero
  logic                          m_tuser;         // [0] overflow

  stim_item_t  stim_q[$];
  lcs_result_t lcs_due_q[$];

  // tracker state: stored A, one DP row, run flags
  logic [lcs_pkg::DATA_W-1:0]    a_store [LCS_MAX];
  logic [lcs_pkg::LEN_OUT_W-1:0] row_val [LCS_MAX];
  int unsigned                   a_len     = 0;
  int unsigned                   b_taken   = 0;
  bit                            run_ovf   = 1'b0;
  bit                            a_loading = 1'b0;
  bit                            a_cut     = 1'b0;

  // per-run element alphabet, small so that matches are common
  logic [lcs_pkg::DATA_W-1:0] alpha [4];
  int                         alpha_n = 1;

  idle_phase_t cur_phase   = PH_RX_SLOW;
  int          hold_reqs   = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  bit          s_taken     = 1'b0;
  int          error_count = 0;

  lcs_length_engine #(.MAX_LEN(LCS_MAX)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Update the tracked row for one accepted beat; queue a result on the last B beat.
  function automatic void track_lcs_beat(logic cmd, logic [lcs_pkg::DATA_W-1:0] v, logic fin);
    logic [lcs_pkg::LEN_OUT_W-1:0] diag, above, left, nv;
    lcs_result_t res;
    if (cmd == lcs_pkg::CMD_FIRST) begin
      // an A beat with no A open starts a fresh A and drops any B in progress
      if (!a_loading) begin
        a_len   = 0;
        run_ovf = 1'b0;
        a_cut   = 1'b0;
        b_taken = 0;
      end
      if (a_len < LCS_MAX) begin
        a_store[a_len] = v;
        a_len++;
      end else begin
        run_ovf = 1'b1;
        a_cut   = 1'b1;
      end
      a_loading = !fin;
    end else begin
      a_loading = 1'b0;
      if (b_taken == 0) begin
        foreach (row_val[k]) row_val[k] = '0;
        run_ovf = a_cut;
      end
      if (b_taken < LCS_MAX) begin
        diag  = '0;
        above = '0;
        for (int i = 0; i < a_len; i++) begin
          left = row_val[i];
          if (a_store[i] == v) nv = diag + 1'b1;
          else nv = (left > above) ? left : above;
          row_val[i] = nv;
          diag  = left;
          above = nv;
        end
        b_taken++;
      end else begin
        run_ovf = 1'b1;
      end
      if (fin) begin
        res.len = (a_len > 0) ? row_val[a_len-1] : '0;
        res.ovf = run_ovf;
        lcs_due_q.push_back(res);
        b_taken = 0;
        run_ovf = a_cut;
      end
    end
  endfunction

  function automatic void push_beat(logic cmd, logic [lcs_pkg::DATA_W-1:0] v, logic fin,
                                    idle_phase_t ph);
    stim_item_t it;
    it.kind  = STIM_BEAT;
    it.phase = ph;
    it.cmd   = cmd;
    it.value = v;
    it.fin   = fin;
    stim_q.push_back(it);
  endfunction

  function automatic void push_marker(stim_kind_t k);
    stim_item_t it;
    it.kind  = k;
    it.phase = PH_FREE;
    it.cmd   = 1'b0;
    it.value = '0;
    it.fin   = 1'b0;
    stim_q.push_back(it);
  endfunction

  function automatic void new_alphabet();
    alpha_n = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(9))
        0: alpha[i] = 32'h8000_0000;
        1: alpha[i] = 32'h7FFF_FFFF;
        2: alpha[i] = '0;
        3: alpha[i] = '1;
        default: alpha[i] = $urandom;
      endcase
    end
  endfunction

  function automatic logic [lcs_pkg::DATA_W-1:0] pick_elem();
    if ($urandom_range(9) == 0) return $urandom;
    return alpha[2'($urandom_range(alpha_n - 1))];
  endfunction

  function automatic void push_seq(logic cmd, int n, logic close, idle_phase_t ph);
    for (int i = 0; i < n; i++) push_beat(cmd, pick_elem(), close && (i == n - 1), ph);
  endfunction

  // One random run: mostly well-formed A then B (with reuse), some broken ones and noise.
  function automatic int add_random_run(idle_phase_t ph);
    int sel, na, nb, reps, n;
    sel = $urandom_range(99);
    na  = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    nb  = $urandom_range(1, 12);
    new_alphabet();
    n = 0;
    if (sel < 70) begin
      reps = $urandom_range(0, 2);
      push_seq(lcs_pkg::CMD_FIRST, na, 1'b1, ph);
      push_seq(lcs_pkg::CMD_SECOND, nb, 1'b1, ph);
      n = na + nb;
      for (int r = 0; r < reps; r++) begin
        nb = $urandom_range(1, 12);
        push_seq(lcs_pkg::CMD_SECOND, nb, 1'b1, ph);
        n += nb;
      end
    end else if (sel < 80) begin
      // A left open, B closes it
      push_seq(lcs_pkg::CMD_FIRST, na, 1'b0, ph);
      push_seq(lcs_pkg::CMD_SECOND, nb, 1'b1, ph);
      n = na + nb;
    end else if (sel < 90) begin
      // B cut short; a later A abandons it
      push_seq(lcs_pkg::CMD_SECOND, nb, 1'b0, ph);
      n = nb;
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        push_beat(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)), ph);
    end
    return n;
  endfunction

  // Sender: one beat offered at a time, markers resolved at the head of the queue
  always @(negedge clk) begin
    int gap_pct;
    stim_item_t it;
    if (!rst && (!s_tvalid || s_taken)) begin
      if (stim_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else begin
        case (stim_q[0].phase)
          PH_RX_SLOW: gap_pct = 22;
          PH_TX_SLOW: gap_pct = 74;
          default:    gap_pct = 0;
        endcase
        case (stim_q[0].kind)
          STIM_HOLD: begin
            hold_reqs <= hold_reqs + 1;
            void'(stim_q.pop_front());
            s_tvalid <= 1'b0;
          end
          STIM_DRAIN: begin
            s_tvalid <= 1'b0;
            if (lcs_due_q.size() == 0) void'(stim_q.pop_front());
          end
          default: begin
            if ($urandom_range(99) < gap_pct) begin
              s_tvalid <= 1'b0;
            end else begin
              it = stim_q.pop_front();
              s_tvalid  <= 1'b1;
              s_tdata   <= it.value;
              s_tuser   <= it.cmd;
              s_tlast   <= it.fin;
              cur_phase <= it.phase;
            end
          end
        endcase
      end
    end
  end

  // Receiver: random stalls per phase, plus a long hold-off on request
  always @(negedge clk) begin
    int stall_pct;
    case (cur_phase)
      PH_RX_SLOW: stall_pct = 74;
      PH_TX_SLOW: stall_pct = 22;
      default:    stall_pct = 0;
    endcase
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: track accepted input beats, check each result beat
  always @(posedge clk) begin
    lcs_result_t want;
    s_taken = s_tvalid && s_tready;
    if (!rst) begin
      if (s_taken) track_lcs_beat(s_tuser, s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (lcs_due_q.size() == 0) begin
          report_mismatch($sformatf("result len=%0d ovf=%0b with none pending",
                                    m_tdata[lcs_pkg::LEN_OUT_W-1:0], m_tuser));
        end else begin
          want = lcs_due_q.pop_front();
          if (m_tdata[lcs_pkg::LEN_OUT_W-1:0] !== want.len)
            report_mismatch($sformatf("lcs_length got %0d want %0d",
                                      m_tdata[lcs_pkg::LEN_OUT_W-1:0], want.len));
          if (m_tdata[lcs_pkg::M_TDATA_W-1:lcs_pkg::LEN_OUT_W] !== '0)
            report_mismatch($sformatf("m_tdata pad bits got %h", m_tdata));
          if (m_tuser !== want.ovf)
            report_mismatch($sformatf("overflow got %b want %b", m_tuser, want.ovf));
        end
      end
    end
  end

  initial begin
    logic [lcs_pkg::DATA_W-1:0] big_a[$];
    int made;
    int cycles;

    // directed: empty A, field extremes, reuse, no match, open A, abandoned B
    push_beat(lcs_pkg::CMD_SECOND, 32'h0000_0001, 1'b1, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_FIRST, 32'h8000_0000, 1'b0, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_FIRST, 32'h7FFF_FFFF, 1'b0, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_FIRST, 32'h0000_0000, 1'b0, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_FIRST, 32'hFFFF_FFFF, 1'b1, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_SECOND, 32'h8000_0000, 1'b0, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_SECOND, 32'h7FFF_FFFF, 1'b0, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_SECOND, 32'h0000_0000, 1'b0, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_SECOND, 32'hFFFF_FFFF, 1'b1, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_SECOND, 32'hFFFF_FFFF, 1'b0, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_SECOND, 32'h8000_0000, 1'b1, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_FIRST, 32'd5, 1'b1, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_SECOND, 32'd6, 1'b1, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_FIRST, 32'd1, 1'b0, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_FIRST, 32'd2, 1'b0, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_SECOND, 32'd2, 1'b0, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_SECOND, 32'd1, 1'b1, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_FIRST, 32'd3, 1'b1, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_SECOND, 32'd3, 1'b0, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_FIRST, 32'd4, 1'b1, PH_RX_SLOW);
    push_beat(lcs_pkg::CMD_SECOND, 32'd4, 1'b1, PH_RX_SLOW);
    push_marker(STIM_DRAIN);

    // random: slow receiver, then slow sender, then free running
    made = 0;
    while (made < RANDOM_ITEMS / 6) made += add_random_run(PH_RX_SLOW);
    push_marker(STIM_DRAIN);
    while (made < RANDOM_ITEMS / 3) made += add_random_run(PH_RX_SLOW);
    push_marker(STIM_DRAIN);
    while (made < 2 * RANDOM_ITEMS / 3) made += add_random_run(PH_TX_SLOW);
    push_marker(STIM_DRAIN);
    // long receiver hold-off while short runs keep coming
    push_marker(STIM_HOLD);
    while (made < RANDOM_ITEMS) made += add_random_run(PH_FREE);
    push_marker(STIM_DRAIN);

    // A one past capacity, then B one past capacity equal to A, last flag on
    // the dropped B beat: full-length LCS with overflow
    for (int i = 0; i <= LCS_MAX; i++) big_a.push_back($urandom);
    for (int i = 0; i <= LCS_MAX; i++)
      push_beat(lcs_pkg::CMD_FIRST, big_a[i], i == LCS_MAX, PH_FREE);
    for (int i = 0; i <= LCS_MAX; i++)
      push_beat(lcs_pkg::CMD_SECOND, big_a[i], i == LCS_MAX, PH_FREE);
    // reuse of the truncated A keeps the flag
    new_alphabet();
    push_seq(lcs_pkg::CMD_SECOND, 3, 1'b1, PH_FREE);
    // flag clears on the next plain run
    push_seq(lcs_pkg::CMD_FIRST, 3, 1'b1, PH_FREE);
    push_seq(lcs_pkg::CMD_SECOND, 3, 1'b1, PH_FREE);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cycles = 0;
    while ((stim_q.size() != 0 || s_tvalid || lcs_due_q.size() != 0) &&
           cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end

    if (cycles >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycles, lcs_due_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (error_count == 0 && lcs_due_q.size() == 0) begin
        $display("Testbench completed without errors");
      end else begin
        $display("Testbench completed WITH ERRORS");
      end
      $finish;
    end
  end

endmodule

@@ sim.f @@
hdl/lcs_pkg.sv
hdl/lcs_seq_mem.sv
hdl/lcs_row_unit.sv
hdl/lcs_length_engine.sv
tb/sv/tb.sv
